FILE: rtl/linear_prime_sieve_core_defines.svh
// Assertion macros used by the sieve core.
`ifndef LINEAR_PRIME_SIEVE_CORE_DEFINES_SVH
`define LINEAR_PRIME_SIEVE_CORE_DEFINES_SVH

// Condition holds at every edge out of reset.
`define LPS_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define LPS_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lps_pkg.sv
// Shared types and constants of the linear prime sieve.
package lps_pkg;

  localparam int unsigned LIMIT_W         = 16;
  localparam int unsigned VALUE_W         = 16;
  localparam int unsigned FUNC_W          = 2;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned FACTOR_W        = 16;
  localparam int unsigned COUNT_OUT_W     = 14;
  localparam int unsigned DEF_MAX_VALUE   = 65535;
  localparam int unsigned DEF_PRIME_SLOTS = 8192;
  localparam int unsigned FIRST_PRIME     = 2;
  localparam int unsigned FIRST_ODD       = 3;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_BUILD  = 2'd0,
    FUNC_FACTOR = 2'd1,
    FUNC_RANK   = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_RANGE     = 2'd1,
    STATUS_NOT_BUILT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    QSEL_NONE,
    QSEL_FACTOR,
    QSEL_RANK
  } qsel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_QUERY,
    ST_FILL,
    ST_WALK,
    ST_XCHK,
    ST_PRD,
    ST_PMUL,
    ST_PMARK,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/linear_prime_sieve_core.sv
// Top level of the linear prime sieve: control, factor table and prime list.
//
//   channel  direction  handshake            word
//   cfg      in         cfg_valid/cfg_ready  limit
//   req      in         req_valid/req_stall  func, value
//   rsp      out        rsp_valid/rsp_stall  status, smallest_factor, is_prime,
//                                            prime_value, prime_count
//
// A query is accepted, then one read of the factor or prime memory gives its result.
// A build on effective limit n fills n+1 table entries, then walks the odd values;
// each is checked against its entry, then marked with each listed prime in turn until
// the prime passes its smallest factor, the product passes n or every prime was tried.
// Reset needs no clearing pass; limit returns to 65535 and the table is unbuilt.
// A stalled result holds in the output register; a next request is taken but waits.
`include "linear_prime_sieve_core_defines.svh"

module linear_prime_sieve_core #(
  parameter int unsigned MAX_VALUE   = lps_pkg::DEF_MAX_VALUE,
  parameter int unsigned PRIME_SLOTS = lps_pkg::DEF_PRIME_SLOTS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lps_pkg::LIMIT_W-1:0]      limit,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [lps_pkg::FUNC_W-1:0]       func,
  input  logic [lps_pkg::VALUE_W-1:0]      value,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [lps_pkg::STATUS_W-1:0]     status,
  output logic [lps_pkg::FACTOR_W-1:0]     smallest_factor,
  output logic                             is_prime,
  output logic [lps_pkg::FACTOR_W-1:0]     prime_value,
  output logic [lps_pkg::COUNT_OUT_W-1:0]  prime_count
);

  import lps_pkg::*;

  localparam int unsigned DEPTH  = MAX_VALUE + 1;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned PW     = $clog2(PRIME_SLOTS);
  localparam int unsigned CW     = $clog2(PRIME_SLOTS + 1);
  localparam int unsigned XW     = LIMIT_W + 1;
  localparam int unsigned PROD_W = 2 * LIMIT_W;

  state_t               state, state_next;
  logic [LIMIT_W-1:0]   limit_reg;
  logic [LIMIT_W-1:0]   lim_eff;
  logic                 table_ready;
  logic [CW-1:0]        count;
  logic [AW-1:0]        fill_addr;
  logic [XW-1:0]        x;
  logic [CW-1:0]        k;
  logic [FACTOR_W-1:0]  fx;
  logic [FACTOR_W-1:0]  p;
  logic [PROD_W-1:0]    prod;
  logic                 p_big;
  status_t              q_status, q_status_next;
  qsel_t                q_sel, q_sel_next;
  logic [VALUE_W-1:0]   q_value;

  logic                 accept;
  logic                 out_free;
  logic                 load_out;
  logic                 x_in;
  logic                 new_prime;
  logic                 mark_hit;
  logic                 k_end;

  logic                 fac_we, fac_re;
  logic [AW-1:0]        fac_waddr, fac_raddr;
  logic [FACTOR_W-1:0]  fac_wdata, fac_rdata;
  logic                 pl_we, pl_re;
  logic [PW-1:0]        pl_waddr, pl_raddr;
  logic [FACTOR_W-1:0]  pl_wdata, pl_rdata;

  lps_ram #(
    .WIDTH  (FACTOR_W),
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_factor_ram (
    .clk   (clk),
    .we    (fac_we),
    .waddr (fac_waddr),
    .wdata (fac_wdata),
    .re    (fac_re),
    .raddr (fac_raddr),
    .rdata (fac_rdata)
  );

  lps_ram #(
    .WIDTH  (FACTOR_W),
    .DEPTH  (PRIME_SLOTS),
    .ADDR_W (PW)
  ) u_prime_ram (
    .clk   (clk),
    .we    (pl_we),
    .waddr (pl_waddr),
    .wdata (pl_wdata),
    .re    (pl_re),
    .raddr (pl_raddr),
    .rdata (pl_rdata)
  );

  always_comb begin
    lim_eff = limit_reg;
    if (limit_reg < LIMIT_W'(FIRST_PRIME)) begin
      lim_eff = LIMIT_W'(FIRST_PRIME);
    end
    if (32'(limit_reg) > 32'(MAX_VALUE)) begin
      lim_eff = LIMIT_W'(MAX_VALUE);
    end
  end

  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign load_out  = ((state == ST_QUERY) || (state == ST_DONE)) && out_free;
  assign x_in      = x <= XW'(lim_eff);
  assign new_prime = (fac_rdata == FACTOR_W'(FIRST_PRIME)) &&
                     (32'(count) < 32'(PRIME_SLOTS));
  assign mark_hit  = !p_big && (prod <= PROD_W'(lim_eff));
  assign k_end     = k == count;

  assign req_stall = state != ST_IDLE;
  assign cfg_ready = state == ST_IDLE;

  always_comb begin
    q_status_next = STATUS_OK;
    q_sel_next    = QSEL_NONE;
    unique case (func)
      FUNC_BUILD: begin
        q_status_next = STATUS_OK;
      end
      FUNC_FACTOR: begin
        if (!table_ready) begin
          q_status_next = STATUS_NOT_BUILT;
        end else if (value > lim_eff) begin
          q_status_next = STATUS_RANGE;
        end else if (value >= VALUE_W'(FIRST_PRIME)) begin
          q_sel_next = QSEL_FACTOR;
        end
      end
      FUNC_RANK: begin
        if (!table_ready) begin
          q_status_next = STATUS_NOT_BUILT;
        end else if (32'(value) >= 32'(count)) begin
          q_status_next = STATUS_RANGE;
        end else begin
          q_sel_next = QSEL_RANK;
        end
      end
      default: begin
        q_status_next = STATUS_RANGE;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (func == FUNC_BUILD) ? ST_FILL : ST_QUERY;
        end
      end
      ST_QUERY: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_FILL: begin
        if (fill_addr == AW'(lim_eff)) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        state_next = x_in ? ST_XCHK : ST_DONE;
      end
      ST_XCHK: begin
        state_next = ST_PRD;
      end
      ST_PRD: begin
        state_next = k_end ? ST_WALK : ST_PMUL;
      end
      ST_PMUL: begin
        state_next = ST_PMARK;
      end
      ST_PMARK: begin
        state_next = mark_hit ? ST_PRD : ST_WALK;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    fac_we    = 1'b0;
    fac_waddr = fill_addr;
    fac_wdata = FACTOR_W'(FIRST_PRIME);
    fac_re    = 1'b0;
    fac_raddr = AW'(x);
    pl_we     = 1'b0;
    pl_waddr  = PW'(count);
    pl_wdata  = FACTOR_W'(x);
    pl_re     = 1'b0;
    pl_raddr  = PW'(k);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (func == FUNC_BUILD) begin
            pl_we    = 1'b1;
            pl_waddr = '0;
            pl_wdata = FACTOR_W'(FIRST_PRIME);
          end
          fac_re   = q_sel_next == QSEL_FACTOR;
          fac_raddr = AW'(value);
          pl_re    = q_sel_next == QSEL_RANK;
          pl_raddr = PW'(value);
        end
      end
      ST_FILL: begin
        fac_we = 1'b1;
      end
      ST_WALK: begin
        fac_re = x_in;
      end
      ST_XCHK: begin
        fac_we    = new_prime;
        fac_waddr = AW'(x);
        fac_wdata = FACTOR_W'(x);
        pl_we     = new_prime;
      end
      ST_PRD: begin
        pl_re = !k_end;
      end
      ST_PMARK: begin
        fac_we    = mark_hit;
        fac_waddr = AW'(prod);
        fac_wdata = p;
      end
      default: begin
        fac_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      limit_reg   <= LIMIT_RESET;
      table_ready <= 1'b0;
      count       <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        limit_reg   <= limit;
        table_ready <= 1'b0;
        count       <= '0;
      end
      if (accept && (func == FUNC_BUILD)) begin
        count <= CW'(1);
      end
      if ((state == ST_XCHK) && new_prime) begin
        count <= count + CW'(1);
      end
      if ((state == ST_DONE) && out_free) begin
        table_ready <= 1'b1;
      end
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          q_status  <= q_status_next;
          q_sel     <= q_sel_next;
          q_value   <= value;
          fill_addr <= '0;
          x         <= XW'(FIRST_ODD);
        end
      end
      ST_FILL: begin
        fill_addr <= fill_addr + AW'(1);
      end
      ST_XCHK: begin
        fx <= new_prime ? FACTOR_W'(x) : fac_rdata;
        k  <= '0;
      end
      ST_PRD: begin
        if (k_end) begin
          x <= x + XW'(2);
        end
      end
      ST_PMUL: begin
        p     <= pl_rdata;
        prod  <= PROD_W'(pl_rdata) * PROD_W'(x[LIMIT_W-1:0]);
        p_big <= pl_rdata > fx;
      end
      ST_PMARK: begin
        if (mark_hit) begin
          k <= k + CW'(1);
        end else begin
          x <= x + XW'(2);
        end
      end
      default: begin
        p_big <= p_big;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      prime_count <= COUNT_OUT_W'(count);
      if (state == ST_QUERY) begin
        status          <= q_status;
        smallest_factor <= (q_sel == QSEL_FACTOR) ? fac_rdata : '0;
        is_prime        <= (q_sel == QSEL_FACTOR) && (fac_rdata == q_value);
        prime_value     <= (q_sel == QSEL_RANK) ? pl_rdata : '0;
      end else begin
        status          <= STATUS_OK;
        smallest_factor <= '0;
        is_prime        <= 1'b0;
        prime_value     <= '0;
      end
    end
  end

  `LPS_ASSERT_HOLDS(a_count_bound, 32'(count) <= 32'(PRIME_SLOTS),
                    "prime count over slots")
  `LPS_ASSERT_IMPLIES(a_ready_has_primes, table_ready, count != '0,
                      "built table has no primes")
  `LPS_ASSERT_IMPLIES(a_mark_above_x, (state == ST_PMARK) && mark_hit, prod > PROD_W'(x),
                      "mark at or below walked value")
  `LPS_ASSERT_IMPLIES(a_walk_odd, (state == ST_XCHK) || (state == ST_PRD) ||
                      (state == ST_PMUL) || (state == ST_PMARK), x[0], "walked value is even")

endmodule

FILE: rtl/lps_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module lps_ram #(
  parameter int unsigned WIDTH  = 16,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
